/* src/ecdt_pkg.sv */
// Shared constants, control word type and tables for the epoch-to-date converter.
`timescale 1ns / 1ps

package ecdt_pkg;

  localparam int unsigned PcW = 4;

  // Divisors for the three divisions.
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [16:0] SecsPerHour = 17'd3600;
  localparam logic [16:0] SecsPerMin  = 17'd60;

  // A day is 128 * 675 seconds, an hour 16 * 225 and a minute 4 * 15. Each division
  // shifts the dividend right by the power of two, multiplies by the rounded-up
  // reciprocal of the odd part and keeps the bits above the reciprocal's scale.
  localparam logic [25:0] RecipDay  = 26'd50903317;  // 2^35 / 675, rounded up
  localparam logic [25:0] RecipHour = 26'd9321;      // 2^21 / 225, rounded up
  localparam logic [25:0] RecipMin  = 26'd1093;      // 2^14 / 15, rounded up

  // Calendar counters at the epoch year 1970: year mod 4, mod 100, mod 400.
  localparam logic [1:0] EpochMod4   = 2'd2;
  localparam logic [6:0] EpochMod100 = 7'd70;
  localparam logic [8:0] EpochMod400 = 9'd370;

  localparam logic [3:0] MonthDec = 4'd11;
  localparam logic [3:0] MonthFeb = 4'd1;

  // Datapath operations.
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_DIV   = 3'd2;
  localparam logic [2:0] OP_REM   = 3'd3;
  localparam logic [2:0] OP_YEAR  = 3'd4;
  localparam logic [2:0] OP_MONTH = 3'd5;
  localparam logic [2:0] OP_EMIT  = 3'd6;

  // Divisor selects.
  localparam logic [1:0] DSEL_DAY  = 2'd0;
  localparam logic [1:0] DSEL_HOUR = 2'd1;
  localparam logic [1:0] DSEL_MIN  = 2'd2;

  // Jump conditions: when true, the step counter goes to the target.
  localparam logic [2:0] COND_NEVER  = 3'd0;
  localparam logic [2:0] COND_IDLE   = 3'd1;
  localparam logic [2:0] COND_WALK   = 3'd2;
  localparam logic [2:0] COND_ALWAYS = 3'd3;

  typedef struct packed {
    logic [2:0]     op;
    logic [1:0]     dsel;
    logic [2:0]     cond;
    logic [PcW-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic walk_more;
  } dp_status_t;

  // Control store.
  function automatic ctrl_word_t ecdt_ucode(input logic [PcW-1:0] pc);
    ctrl_word_t w;
    w = '{op: OP_NOP, dsel: DSEL_DAY, cond: COND_ALWAYS, target: '0};
    unique case (pc)
      4'd0: w = '{op: OP_LOAD, dsel: DSEL_DAY, cond: COND_IDLE, target: 4'd0};
      4'd1: w = '{op: OP_DIV, dsel: DSEL_DAY, cond: COND_NEVER, target: '0};
      4'd2: w = '{op: OP_REM, dsel: DSEL_DAY, cond: COND_NEVER, target: '0};
      4'd3: w = '{op: OP_DIV, dsel: DSEL_HOUR, cond: COND_NEVER, target: '0};
      4'd4: w = '{op: OP_REM, dsel: DSEL_HOUR, cond: COND_NEVER, target: '0};
      4'd5: w = '{op: OP_DIV, dsel: DSEL_MIN, cond: COND_NEVER, target: '0};
      4'd6: w = '{op: OP_REM, dsel: DSEL_MIN, cond: COND_NEVER, target: '0};
      4'd7: w = '{op: OP_YEAR, dsel: DSEL_DAY, cond: COND_WALK, target: 4'd7};
      4'd8: w = '{op: OP_MONTH, dsel: DSEL_DAY, cond: COND_WALK, target: 4'd8};
      4'd9: w = '{op: OP_EMIT, dsel: DSEL_DAY, cond: COND_ALWAYS, target: 4'd0};
      default: w = '{op: OP_NOP, dsel: DSEL_DAY, cond: COND_ALWAYS, target: '0};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      MonthFeb:                  len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* src/epoch_seconds_to_date_time.sv */
// Top level of the Unix time to calendar month, day, hour and minute converter.
//
//   Channel   Signals                                   Direction
//   command   start, busy, epoch_seconds                in (accepted on start && !busy)
//   result    valid, month_index, day_of_month,         out (one cycle strobe)
//             hour_of_day, minute_of_hour
//
// From acceptance to the result strobe an item runs three divisions of two steps each,
// one step per year walked from 1970 (up to 136) plus one to leave the walk, one per
// month walked plus one, and one step to emit; years and months walked together reach
// at most 146.
// Reset is synchronous and returns the step counter to idle; no clearing pass is needed.
// A new command may be accepted in the same cycle the result strobe is shown.
`timescale 1ns / 1ps

module epoch_seconds_to_date_time import ecdt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds,
  output logic        valid,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour
);

  ctrl_word_t ctrl;
  dp_status_t status;

  ecdt_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  ecdt_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .epoch_seconds  (epoch_seconds),
    .ctrl           (ctrl),
    .status         (status),
    .done           (valid),
    .month_index    (month_index),
    .day_of_month   (day_of_month),
    .hour_of_day    (hour_of_day),
    .minute_of_hour (minute_of_hour)
  );

endmodule

/* src/ecdt_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps

module ecdt_seq import ecdt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_word_t ctrl,
  output logic       busy
);

  logic [PcW-1:0] pc;
  logic [PcW-1:0] pc_next;
  logic           take;

  assign ctrl = ecdt_ucode(pc);
  assign busy = (pc != '0);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:  take = 1'b0;
      COND_IDLE:   take = !start;
      COND_WALK:   take = status.walk_more;
      COND_ALWAYS: take = 1'b1;
      default:     take = 1'b1;
    endcase
    pc_next = take ? ctrl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* src/ecdt_datapath.sv */
// Datapath: reciprocal-multiply divider, year and month walk counters, result registers.
`timescale 1ns / 1ps

module ecdt_datapath import ecdt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] epoch_seconds,
  input  ctrl_word_t  ctrl,
  output dp_status_t  status,
  output logic        done,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour
);

  logic [31:0] num;
  logic [15:0] quo;
  logic [15:0] days;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [3:0]  month;
  logic [1:0]  c4;
  logic [6:0]  c100;
  logic [8:0]  c400;

  logic [16:0] divisor;
  logic [24:0] mul_a;
  logic [25:0] mul_b;
  logic [50:0] prod;
  logic [15:0] recip_q;
  logic [31:0] back;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic        year_more;
  logic        month_more;

  always_comb begin
    // For the hour and minute divisions the dividend is below the divisor of the previous stage.
    case (ctrl.dsel)
      DSEL_HOUR: begin
        divisor = SecsPerHour;
        mul_a   = {12'd0, num[16:4]};
        mul_b   = RecipHour;
      end
      DSEL_MIN: begin
        divisor = SecsPerMin;
        mul_a   = {15'd0, num[11:2]};
        mul_b   = RecipMin;
      end
      default: begin
        divisor = SecsPerDay;
        mul_a   = num[31:7];
        mul_b   = RecipDay;
      end
    endcase
    prod = {26'd0, mul_a} * {25'd0, mul_b};
    case (ctrl.dsel)
      DSEL_HOUR: recip_q = prod[36:21];
      DSEL_MIN:  recip_q = prod[29:14];
      default:   recip_q = prod[50:35];
    endcase
    back = {16'd0, quo} * {15'd0, divisor};

    leap = ((c4 == 2'd0) && (c100 != 7'd0)) || (c400 == 9'd0);
    ylen = leap ? 9'd366 : 9'd365;
    mlen = month_len(month, leap);

    year_more  = (days >= {7'd0, ylen});
    month_more = (month != MonthDec) && (days >= {11'd0, mlen});
  end

  assign status.walk_more = (ctrl.op == OP_YEAR) ? year_more : month_more;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctrl.op == OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        if (start) begin
          num   <= epoch_seconds;
          month <= '0;
          c4    <= EpochMod4;
          c100  <= EpochMod100;
          c400  <= EpochMod400;
        end
      end
      OP_DIV: begin
        quo <= recip_q;
      end
      OP_REM: begin
        num <= num - back;
        case (ctrl.dsel)
          DSEL_HOUR: hour   <= quo[4:0];
          DSEL_MIN:  minute <= quo[5:0];
          default:   days   <= quo;
        endcase
      end
      OP_YEAR: begin
        if (year_more) begin
          days <= days - {7'd0, ylen};
          c4   <= c4 + 1'b1;
          c100 <= (c100 == 7'd99) ? 7'd0 : c100 + 1'b1;
          c400 <= (c400 == 9'd399) ? 9'd0 : c400 + 1'b1;
        end
      end
      OP_MONTH: begin
        if (month_more) begin
          days  <= days - {11'd0, mlen};
          month <= month + 1'b1;
        end
      end
      OP_EMIT: begin
        month_index    <= month;
        day_of_month   <= days[4:0] + 1'b1;
        hour_of_day    <= hour;
        minute_of_hour <= minute;
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/ecdt_check.sv */
// Port-level checker for the epoch-to-date converter, bound to the top level.
`timescale 1ns / 1ps

module ecdt_check (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        valid,
  input logic [3:0]  month_index,
  input logic [4:0]  day_of_month,
  input logic [4:0]  hour_of_day,
  input logic [5:0]  minute_of_hour
);

  // A result is shown only once the converter is back to idle.
  a_valid_idle: assert property (@(posedge clk) disable iff (rst) valid |-> !busy)
    else $error("result strobe while busy");

  // An accepted transfer keeps the converter busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not start work");

  // Finishing work always produces a result.
  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> valid)
    else $error("work finished without a result");

  // Result fields stay in their calendar ranges.
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    valid |-> (month_index <= 4'd11) && (day_of_month != 5'd0) &&
              (hour_of_day <= 5'd23) && (minute_of_hour <= 6'd59))
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_date_time ecdt_check u_check (.*);

/* verif/tb_top.sv */
// Self-checking testbench for the epoch seconds to calendar month, day, hour and minute converter.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DaySeconds    = 86400;
  localparam int unsigned HourSeconds   = 3600;
  localparam int unsigned MinuteSeconds = 60;
  localparam int unsigned EpochYear     = 1970;
  localparam int unsigned LastDay       = 49710;  // day number of 0xFFFFFFFF
  localparam int unsigned DrainCycles   = 250;
  localparam int unsigned RandomItems   = 1330;

  localparam int unsigned CommonMonthDays [12] = '{31, 28, 31, 30, 31, 30,
                                                   31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] mday;
    logic [4:0] hour;
    logic [5:0] minute;
  } civil_stamp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] epoch_seconds = '0;
  logic        valid;
  logic [3:0]  month_index;
  logic [4:0]  day_of_month;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;

  civil_stamp_t expected_stamps [$];
  int unsigned  error_count = 0;

  epoch_seconds_to_date_time u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .epoch_seconds (epoch_seconds),
    .valid         (valid),
    .month_index   (month_index),
    .day_of_month  (day_of_month),
    .hour_of_day   (hour_of_day),
    .minute_of_hour(minute_of_hour)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_leap_year(input int unsigned year);
    return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
  endfunction

  // Steps whole years off from the epoch, then whole months off the remaining days.
  function automatic civil_stamp_t predict_civil_stamp(input logic [31:0] stamp);
    civil_stamp_t s;
    int unsigned  secs;
    int unsigned  days;
    int unsigned  sod;
    int unsigned  year;
    int unsigned  month;
    int unsigned  span;
    secs     = stamp;
    days     = secs / DaySeconds;
    sod      = secs % DaySeconds;
    s.hour   = 5'(sod / HourSeconds);
    s.minute = 6'((sod % HourSeconds) / MinuteSeconds);
    year     = EpochYear;
    forever begin
      span = is_leap_year(year) ? 366 : 365;
      if (days < span) break;
      days -= span;
      year++;
    end
    month = 0;
    while (month < 11) begin
      span = CommonMonthDays[month];
      if (month == 1 && is_leap_year(year)) span = 29;
      if (days < span) break;
      days -= span;
      month++;
    end
    s.month = 4'(month);
    s.mday  = 5'(days + 1);
    return s;
  endfunction

  function automatic logic [31:0] pick_timestamp();
    int unsigned day;
    case ($urandom_range(3))
      2: begin
        day = $urandom_range(LastDay);
        return day * DaySeconds + $urandom_range(59);
      end
      3: begin
        day = $urandom_range(LastDay - 1);
        return day * DaySeconds + DaySeconds - 1 - $urandom_range(59);
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Called right after a rising edge; returns right after the edge of the transfer.
  task automatic send_timestamp(input logic [31:0] stamp, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    epoch_seconds <= stamp;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_stamps.push_back(predict_civil_stamp(stamp));
  endtask

  always @(posedge clk) begin
    civil_stamp_t want;
    if (!rst && valid) begin
      if (expected_stamps.size() == 0) begin
        report_mismatch("result strobe with no transfer outstanding");
      end else begin
        want = expected_stamps.pop_front();
        if (month_index !== want.month)
          report_mismatch($sformatf("month_index got %0d want %0d", month_index, want.month));
        if (day_of_month !== want.mday)
          report_mismatch($sformatf("day_of_month got %0d want %0d", day_of_month, want.mday));
        if (hour_of_day !== want.hour)
          report_mismatch($sformatf("hour_of_day got %0d want %0d", hour_of_day, want.hour));
        if (minute_of_hour !== want.minute)
          report_mismatch($sformatf("minute_of_hour got %0d want %0d",
                                    minute_of_hour, want.minute));
      end
    end
  end

  task automatic test_field_extremes();
    send_timestamp(32'h0000_0000, 0);
    send_timestamp(32'hFFFF_FFFF, 0);
    send_timestamp(32'h7FFF_FFFF, 0);
    send_timestamp(32'h8000_0000, 0);
    send_timestamp(32'hAAAA_AAAA, 0);
    send_timestamp(32'h5555_5555, 0);
    // Seconds within the minute are truncated, never rounded.
    send_timestamp(32'd59, 0);
    send_timestamp(32'd60, 0);
    send_timestamp(32'd86399, 0);
    send_timestamp(32'd86400, 0);
  endtask

  task automatic test_month_and_year_edges();
    send_timestamp(32'd2678399, 0);   // last second of January 1970
    send_timestamp(32'd5097599, 0);   // last second of February 1970
    send_timestamp(32'd31449600, 0);  // December 31st 1970
    send_timestamp(32'd94694340, 0);  // last minute of 1972
    send_timestamp(32'd94694400, 0);  // first second of 1973
  endtask

  task automatic test_leap_rules();
    send_timestamp(32'd68169600, 0);    // February 29th 1972
    send_timestamp(32'd951782400, 0);   // February 29th 2000, divisible by 400
    send_timestamp(32'd951868800, 0);   // March 1st 2000
    send_timestamp(32'd4107542399, 0);  // 2100 is a century year and not leap
    send_timestamp(32'd4107542400, 0);
  endtask

  task automatic test_random_timestamps(input int unsigned count, input int unsigned idle_pct);
    repeat (count) send_timestamp(pick_timestamp(), idle_pct);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_month_and_year_edges();
    test_leap_rules();
    test_random_timestamps(RandomItems / 3, 12);
    test_random_timestamps(RandomItems / 3, 62);
    test_random_timestamps(RandomItems - 2 * (RandomItems / 3), 0);
    start <= 1'b0;
    while (expected_stamps.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("epoch_seconds_to_date_time: match");
    end else begin
      $display("epoch_seconds_to_date_time: mismatch");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TIMEOUT with %0d results outstanding", expected_stamps.size());
    $display("epoch_seconds_to_date_time: mismatch");
    $finish;
  end

endmodule
